### src/deadline_timer_queue_defines.svh
// Assertion macros shared by the timer queue modules.
// Each macro expands to one labeled concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define DTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/dtq_pkg.sv
package dtq_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int RESULTS_CAP   = 16;
    localparam int FIRE_CNT_W    = $clog2(RESULTS_CAP);
    localparam int SLOT_ID_W     = 4;
    localparam int TIME_W        = 64;

    localparam logic [TIME_W-1:0] NONE_DEADLINE = '1;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_DISARM = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_ALREADY_QUEUED = 2'd1,
        ST_NOT_QUEUED     = 2'd2,
        ST_DISALLOWED     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [TIME_W-1:0]    deadline;
        logic [TIME_W-1:0]    now;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic                 fired;
        logic [SLOT_ID_W-1:0] fired_slot;
        logic [TIME_W-1:0]    next_deadline;
        logic                 last;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic    accept;
        logic    arm_commit;
        logic    clr_req;
        logic    clr_best;
        logic    clr_min;
        logic    scan_init;
        logic    scan_step;
        logic    commit_scan;
        logic    emit;
        t_status emit_status;
        logic    emit_fired;
        logic    emit_last;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_status arm_status;
        logic    disarm_ok;
        logic    tick_fire;
        logic    scan_end;
        logic    scan_more;
    } t_dp_status;

endpackage

### src/dtq_ctrl.sv
`include "deadline_timer_queue_defines.svh"

module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_opcode,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_tick, n_tick;
    logic [FIRE_CNT_W-1:0] r_fires, n_fires;

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        n_fires = r_fires;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_tick       = (i_opcode == OP_TICK);
                    n_fires      = '0;
                    case (i_opcode)
                        OP_ARM: begin
                            o_cmd.arm_commit  = (i_status.arm_status == ST_OK);
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = i_status.arm_status;
                            o_cmd.emit_last   = 1'b1;
                        end
                        OP_DISARM: begin
                            if (i_status.disarm_ok) begin
                                o_cmd.clr_req   = 1'b1;
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SCAN;
                            end else begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_NOT_QUEUED;
                                o_cmd.emit_last   = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (i_status.tick_fire) begin
                                o_cmd.clr_best  = 1'b1;
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SCAN;
                            end else begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit_scan = 1'b1;
                o_cmd.emit        = 1'b1;
                if (r_tick) begin
                    o_cmd.emit_fired = 1'b1;
                    if (r_fires == FIRE_CNT_W'(RESULTS_CAP - 1) || !i_status.scan_more) begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        // Fire the next earliest slot and rescan.
                        o_cmd.clr_min   = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_fires         = FIRE_CNT_W'(r_fires + 1'b1);
                        n_state         = S_SCAN;
                    end
                end else begin
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= 1'b0;
            r_fires <= '0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_fires <= n_fires;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `DTQ_ASSERT_NEXT(a_done_last_to_idle, i_clk, i_rst_n, (r_state == S_DONE) && o_cmd.emit_last, r_state == S_IDLE)
    `DTQ_ASSERT_IMPLY(a_fired_only_on_tick, i_clk, i_rst_n, o_cmd.emit_fired, r_tick && (r_state == S_DONE))

endmodule

### src/dtq_dp.sv
`include "deadline_timer_queue_defines.svh"

module dtq_dp
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_request   i_req,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_strobe,
    output t_result    o_result
);

    localparam int SLOT_AW = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);

    logic [TIME_W-1:0]    r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_queued, n_queued;
    logic [TIME_W-1:0]    r_earliest, n_earliest;
    logic [SLOT_AW-1:0]   r_best, n_best;
    logic [SLOT_AW-1:0]   r_fire_slot;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_min;
    logic [SLOT_AW-1:0]   r_min_idx;
    logic [CNT_W-1:0]     r_scan_cnt;
    logic [TIME_W-1:0]    r_rd_data;
    logic                 r_rd_q;
    logic [SLOT_AW-1:0]   r_rd_idx;
    logic                 r_rd_vld;
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic [SLOT_AW-1:0]   req_idx;
    logic                 req_in_range;
    logic                 req_queued;
    logic                 arm_lower;
    logic                 arm_tie;
    logic [SLOT_AW-1:0]   rd_addr;
    logic                 rd_go;
    logic                 cmp_take;

    always_comb begin
        req_idx      = SLOT_AW'(i_req.slot_id);
        req_in_range = ({{(32 - SLOT_ID_W){1'b0}}, i_req.slot_id} < 32'(NUM_SLOTS));
        req_queued   = r_queued[req_idx];

        if (i_req.deadline == NONE_DEADLINE) begin
            o_status.arm_status = ST_DISALLOWED;
        end else if (!req_in_range) begin
            o_status.arm_status = ST_NOT_QUEUED;
        end else if (req_queued) begin
            o_status.arm_status = ST_ALREADY_QUEUED;
        end else begin
            o_status.arm_status = ST_OK;
        end
        o_status.disarm_ok = req_in_range && req_queued;
        o_status.tick_fire = (r_earliest != NONE_DEADLINE) && (r_earliest <= i_req.now);
        o_status.scan_end  = (r_scan_cnt == CNT_W'(NUM_SLOTS));
        o_status.scan_more = (r_min != NONE_DEADLINE) && (r_min <= r_now);

        rd_addr  = r_scan_cnt[SLOT_AW-1:0];
        rd_go    = i_cmd.scan_step && !o_status.scan_end;
        cmp_take = r_rd_vld && r_rd_q && (r_rd_data < r_min);

        arm_lower = (i_req.deadline < r_earliest);
        arm_tie   = (i_req.deadline == r_earliest) && (req_idx < r_best);

        if (i_cmd.commit_scan) begin
            n_earliest = r_min;
            n_best     = r_min_idx;
        end else if (i_cmd.arm_commit && (arm_lower || arm_tie)) begin
            n_earliest = i_req.deadline;
            n_best     = req_idx;
        end else begin
            n_earliest = r_earliest;
            n_best     = r_best;
        end

        n_queued = r_queued;
        if (i_cmd.arm_commit) begin
            n_queued[req_idx] = 1'b1;
        end
        if (i_cmd.clr_req) begin
            n_queued[req_idx] = 1'b0;
        end
        if (i_cmd.clr_best) begin
            n_queued[r_best] = 1'b0;
        end
        if (i_cmd.clr_min) begin
            n_queued[r_min_idx] = 1'b0;
        end

        n_out.status        = i_cmd.emit_status;
        n_out.fired         = i_cmd.emit_fired;
        n_out.fired_slot    = i_cmd.emit_fired ? SLOT_ID_W'(r_fire_slot) : '0;
        n_out.next_deadline = n_earliest;
        n_out.last          = i_cmd.emit_last;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued    <= '0;
            r_earliest  <= NONE_DEADLINE;
            r_best      <= '0;
            r_scan_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_queued    <= n_queued;
            r_earliest  <= n_earliest;
            r_best      <= n_best;
            r_rd_vld    <= rd_go;
            r_out_valid <= i_cmd.emit;
            if (i_cmd.scan_init) begin
                r_scan_cnt <= '0;
            end else if (rd_go) begin
                r_scan_cnt <= CNT_W'(r_scan_cnt + 1'b1);
            end
        end
    end

    // Deadline store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm_commit) begin
            r_mem[req_idx] <= i_req.deadline;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd_q   <= r_queued[rd_addr];
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.scan_init) begin
            r_min     <= NONE_DEADLINE;
            r_min_idx <= '0;
        end else if (cmp_take) begin
            r_min     <= r_rd_data;
            r_min_idx <= r_rd_idx;
        end
        if (i_cmd.clr_best) begin
            r_fire_slot <= r_best;
        end else if (i_cmd.clr_min) begin
            r_fire_slot <= r_min_idx;
        end
        if (i_cmd.accept) begin
            r_now <= i_req.now;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    `DTQ_ASSERT_IMPLY(a_fired_slot_dequeued, i_clk, i_rst_n, i_cmd.emit && i_cmd.emit_fired, !r_queued[r_fire_slot])
    `DTQ_ASSERT_IMPLY(a_scan_min_matches_queue, i_clk, i_rst_n, i_cmd.commit_scan, (r_min == NONE_DEADLINE) == (r_queued == '0))

endmodule

### src/deadline_timer_queue.sv
// Arm, refused disarm, idle tick and the unused opcode strobe their result in the cycle after accept.
// Valid disarm: busy while the whole store is scanned (S_SCAN) through the registered store
// read, then in the result state (S_DONE), which emits its result.
// Tick that fires k slots (k <= 16): busy through one rescan and one result per fired slot.
// Reset (synchronous, active low) empties the queue; the deadline store itself is not cleared.
// Results are one-cycle strobes; the receiver cannot stall them.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_req,
    output logic     o_strobe,
    output t_result  o_result
);

    // The controller sequences each request; the datapath holds the slot store,
    // the queued flags, the cached earliest deadline and the scan comparator.
    // The cached earliest deadline and its slot are kept current on arm, so a tick
    // can fire its first slot without a scan. Every removal triggers a full scan
    // of the store (one slot per cycle) to rebuild the minimum, lowest slot on ties.

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    dtq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    dtq_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### bench/tb_deadline_timer_queue.sv
`timescale 1ns / 1ps
module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int         SLOTS         = NUM_SLOTS_DEF;
    localparam int         RESET_CYCLES  = 11;
    localparam int         RANDOM_ITEMS  = 225;
    localparam int         MAX_GAP       = 6;
    localparam int         IDLE_LIMIT    = 1000;
    localparam int         SETTLE_CYCLES = 2 * (SLOTS + 2);
    localparam int         REPORT_MAX    = 10;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef struct {
        t_request req;
        bit       typed;
        t_result  golden;
    } t_plan_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_request i_req   = '0;
    logic     o_strobe;
    t_result  o_result;

    // Typed-in expectation that travels with the request it belongs to.
    logic     golden_en  = 1'b0;
    t_result  golden_res = '0;

    // Shadow copy of the timer queue.
    logic [TIME_W-1:0] shadow_deadline [SLOTS];
    bit                shadow_queued   [SLOTS];
    logic [TIME_W-1:0] shadow_earliest;

    t_result   pending_results[$];
    t_plan_row plan[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        no_gaps     = 1'b0;

    deadline_timer_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lowest queued slot holding the minimum deadline, -1 when the queue is empty.
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_queued[i] && (best < 0 || shadow_deadline[i] < shadow_deadline[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void refresh_earliest();
        int b;
        b = earliest_slot();
        shadow_earliest = (b < 0) ? NONE_DEADLINE : shadow_deadline[b];
    endfunction

    function automatic void push_result(t_status st, logic fired, logic [SLOT_ID_W-1:0] slot,
                                        logic last);
        t_result r;
        r.status        = st;
        r.fired         = fired;
        r.fired_slot    = slot;
        r.next_deadline = shadow_earliest;
        r.last          = last;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow queue by one request and queue up the results it causes.
    function automatic void predict_timer_results(t_request r);
        int      b;
        int      n;
        bit      done;
        t_result tail;
        case (r.opcode)
            OP_ARM: begin
                // Deadline check wins over the queued check.
                if (r.deadline == NONE_DEADLINE) begin
                    push_result(ST_DISALLOWED, 1'b0, '0, 1'b1);
                end else if (int'(r.slot_id) >= SLOTS) begin
                    push_result(ST_NOT_QUEUED, 1'b0, '0, 1'b1);
                end else if (shadow_queued[r.slot_id]) begin
                    push_result(ST_ALREADY_QUEUED, 1'b0, '0, 1'b1);
                end else begin
                    shadow_deadline[r.slot_id] = r.deadline;
                    shadow_queued[r.slot_id]   = 1'b1;
                    if (r.deadline < shadow_earliest)
                        shadow_earliest = r.deadline;
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_DISARM: begin
                if (int'(r.slot_id) >= SLOTS || !shadow_queued[r.slot_id]) begin
                    push_result(ST_NOT_QUEUED, 1'b0, '0, 1'b1);
                end else begin
                    shadow_queued[r.slot_id] = 1'b0;
                    refresh_earliest();
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_TICK: begin
                // Fire expired slots in deadline order, capped per tick.
                n    = 0;
                done = 1'b0;
                while (!done && n < RESULTS_CAP) begin
                    b = earliest_slot();
                    if (b < 0 || shadow_deadline[b] > r.now) begin
                        done = 1'b1;
                    end else begin
                        shadow_queued[b] = 1'b0;
                        refresh_earliest();
                        push_result(ST_OK, 1'b1, b[SLOT_ID_W-1:0], 1'b0);
                        n++;
                    end
                end
                if (n == 0) begin
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                end else begin
                    tail      = pending_results.pop_back();
                    tail.last = 1'b1;
                    pending_results.push_back(tail);
                end
            end
            default: push_result(ST_OK, 1'b0, '0, 1'b1);
        endcase
    endfunction

    function automatic void check_result(t_result want, t_result got);
        if (got.status !== want.status || got.fired !== want.fired ||
            got.fired_slot !== want.fired_slot || got.next_deadline !== want.next_deadline ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("mismatch: expected status=%0d fired=%0b slot=%0d next=%h last=%0b",
                         want.status, want.fired, want.fired_slot, want.next_deadline,
                         want.last);
                $display("          got      status=%0d fired=%0b slot=%0d next=%h last=%0b",
                         got.status, got.fired, got.fired_slot, got.next_deadline, got.last);
            end
        end
    endfunction

    // Check results against the oldest expectation, record accepted requests, watch for hangs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: status=%0d fired=%0b slot=%0d next=%h",
                                 o_result.status, o_result.fired, o_result.fired_slot,
                                 o_result.next_deadline);
                end else begin
                    check_result(pending_results.pop_front(), o_result);
                end
            end
            if (start && !busy) begin
                predict_timer_results(i_req);
                // Swap in the typed-in value; the shadow queue still advances.
                if (golden_en) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(golden_res);
                end
            end
            if (o_strobe || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_request mk_req(logic [1:0] op, logic [SLOT_ID_W-1:0] slot,
                                        logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now_t);
        t_request r;
        r.opcode   = op;
        r.slot_id  = slot;
        r.deadline = dl;
        r.now      = now_t;
        return r;
    endfunction

    // Single-result answer of arm, disarm, idle tick and the unused opcode.
    function automatic t_result mk_res(t_status st, logic [TIME_W-1:0] next_dl);
        t_result r;
        r.status        = st;
        r.fired         = 1'b0;
        r.fired_slot    = '0;
        r.next_deadline = next_dl;
        r.last          = 1'b1;
        return r;
    endfunction

    function automatic void add_row(t_request req, bit typed, t_result golden);
        t_plan_row row;
        row.req    = req;
        row.typed  = typed;
        row.golden = golden;
        plan.push_back(row);
    endfunction

    // Random request around a time base, with some out-of-window and disallowed values.
    function automatic t_request random_request(logic [TIME_W-1:0] base);
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.opcode = OP_ARM;
        else if (pick < 65)
            r.opcode = OP_DISARM;
        else if (pick < 95)
            r.opcode = OP_TICK;
        else
            r.opcode = OP_UNUSED;
        r.slot_id  = SLOT_ID_W'($urandom_range(0, SLOTS - 1));
        r.deadline = base + $urandom_range(0, 1000);
        if ($urandom_range(0, 19) == 0)
            r.deadline = NONE_DEADLINE;
        else if ($urandom_range(0, 19) == 0)
            r.deadline = {$urandom, $urandom};
        r.now = base + $urandom_range(0, 1200);
        if ($urandom_range(0, 9) == 0)
            r.now = {$urandom, $urandom};
        return r;
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    task automatic send_request(t_request req, bit typed, t_result golden);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req      <= req;
        golden_en  <= typed;
        golden_res <= golden;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off new requests until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                sent;
        int                epoch;
        int                len;
        logic [TIME_W-1:0] base;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_deadline[i] = '0;
            shadow_queued[i]   = 1'b0;
        end
        shadow_earliest = NONE_DEADLINE;

        // Directed rows: empty queue, refusals, ties, extremes of time.
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, 64'd0), 1'b1, mk_res(ST_OK, NONE_DEADLINE));
        add_row(mk_req(OP_DISARM,  4'd0,  64'd0, 64'd0), 1'b1,
                mk_res(ST_NOT_QUEUED, NONE_DEADLINE));
        add_row(mk_req(OP_ARM,     4'd0,  NONE_DEADLINE, 64'd0), 1'b1,
                mk_res(ST_DISALLOWED, NONE_DEADLINE));
        add_row(mk_req(OP_UNUSED,  4'd15, NONE_DEADLINE, NONE_DEADLINE), 1'b1,
                mk_res(ST_OK, NONE_DEADLINE));
        add_row(mk_req(OP_ARM,     4'd15, 64'd0, 64'd0), 1'b1, mk_res(ST_OK, 64'd0));
        add_row(mk_req(OP_ARM,     4'd15, 64'd5, 64'd0), 1'b1,
                mk_res(ST_ALREADY_QUEUED, 64'd0));
        add_row(mk_req(OP_ARM,     4'd0,  NONE_DEADLINE - 1, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_ARM,     4'd1,  64'd100, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_ARM,     4'd3,  64'd100, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_ARM,     4'd7,  64'd100, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_DISARM,  4'd7,  64'd0, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, 64'd99), 1'b0, '0);
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, 64'd100), 1'b0, '0);
        add_row(mk_req(OP_DISARM,  4'd7,  64'd0, 64'd0), 1'b1,
                mk_res(ST_NOT_QUEUED, NONE_DEADLINE - 1));
        add_row(mk_req(OP_ARM,     4'd2,  64'h8000_0000_0000_0000, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, 64'h7FFF_FFFF_FFFF_FFFF), 1'b0, '0);
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, NONE_DEADLINE), 1'b0, '0);
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, NONE_DEADLINE), 1'b1,
                mk_res(ST_OK, NONE_DEADLINE));
        add_row(mk_req(OP_ARM,     4'd9,  64'd0, 64'd0), 1'b1, mk_res(ST_OK, 64'd0));
        add_row(mk_req(OP_ARM,     4'd9,  NONE_DEADLINE, 64'd0), 1'b1,
                mk_res(ST_DISALLOWED, 64'd0));
        add_row(mk_req(OP_TICK,    4'd0,  64'd0, 64'd0), 1'b0, '0);
        add_row(mk_req(OP_UNUSED,  4'd9,  64'd123, 64'd456), 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].golden);
        drain_results();

        // Random epochs: each picks a time base and either mixes operations around it or
        // fills every slot and flushes the whole queue in one capped tick.
        sent  = 0;
        epoch = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       base = {$urandom, $urandom};
                1:       base = TIME_W'($urandom_range(0, 500));
                2:       base = NONE_DEADLINE - $urandom_range(0, 3000);
                default: base = {32'($urandom_range(0, 255)), $urandom};
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                for (int s = 0; s < SLOTS; s++)
                    send_request(mk_req(OP_ARM, s[SLOT_ID_W-1:0], base + $urandom_range(0, 8),
                                        {$urandom, $urandom}), 1'b0, '0);
                send_request(mk_req(OP_TICK, 4'($urandom), {$urandom, $urandom}, NONE_DEADLINE),
                             1'b0, '0);
                sent += SLOTS + 1;
            end else begin
                len = $urandom_range(8, 20);
                repeat (len) begin
                    send_request(random_request(base), 1'b0, '0);
                    sent++;
                end
            end
            if (epoch % 5 == 4)
                drain_results();
            epoch++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### deadline_timer_queue.f
+incdir+src
src/dtq_pkg.sv
src/dtq_ctrl.sv
src/dtq_dp.sv
src/deadline_timer_queue.sv
bench/tb_deadline_timer_queue.sv
